### src/cpu_alu_with_flags_assert.svh
// Assertion macros used by the top module of the ALU block.
// Each macro expands to one labeled concurrent assertion that is
// clocked on the rising edge and switched off while reset is high.
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication: the consequent must hold in the cycle of the antecedent.
`define CAWF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define CAWF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cawf_pkg.sv
package cawf_pkg;

   // Field widths of the request and response items.
   localparam int ActionWidth = 5;
   localparam int DataWidth   = 16;
   localparam int FlagWidth   = 8;

   // Operation codes. Codes above ACT_WDEC are unused.
   typedef enum logic [ActionWidth-1:0] {
      ACT_ADD  = 5'd0,
      ACT_ADC  = 5'd1,
      ACT_SUB  = 5'd2,
      ACT_SBC  = 5'd3,
      ACT_AND  = 5'd4,
      ACT_OR   = 5'd5,
      ACT_XOR  = 5'd6,
      ACT_INC  = 5'd7,
      ACT_DEC  = 5'd8,
      ACT_RLC  = 5'd9,
      ACT_RLA  = 5'd10,
      ACT_RRC  = 5'd11,
      ACT_RRA  = 5'd12,
      ACT_SLA  = 5'd13,
      ACT_SRA  = 5'd14,
      ACT_SRL  = 5'd15,
      ACT_WADD = 5'd16,
      ACT_WADC = 5'd17,
      ACT_WSBC = 5'd18,
      ACT_WINC = 5'd19,
      ACT_WDEC = 5'd20
   } action_type;

   // One request item.
   typedef struct packed {
      logic [ActionWidth-1:0] action;
      logic [DataWidth-1:0]   operand_a;
      logic [DataWidth-1:0]   operand_b;
      logic [FlagWidth-1:0]   flags_in;
   } req_payload_type;

   // One response item.
   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic [FlagWidth-1:0] flags_out;
   } rsp_payload_type;

endpackage

### src/cawf_req_if.sv
interface cawf_req_if;
   logic                             valid;
   logic                             ready;
   logic [cawf_pkg::ActionWidth-1:0] action;
   logic [cawf_pkg::DataWidth-1:0]   operand_a;
   logic [cawf_pkg::DataWidth-1:0]   operand_b;
   logic [cawf_pkg::FlagWidth-1:0]   flags_in;

   modport source (output valid, output action, output operand_a, output operand_b,
                   output flags_in, input ready);
   modport sink (input valid, input action, input operand_a, input operand_b,
                 input flags_in, output ready);
endinterface

### src/cawf_rsp_if.sv
interface cawf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cawf_pkg::DataWidth-1:0] result;
   logic [cawf_pkg::FlagWidth-1:0] flags_out;

   modport source (output valid, output result, output flags_out, input ready);
   modport sink (input valid, input result, input flags_out, output ready);
endinterface

### src/cpu_alu_with_flags.sv
// Eight- and sixteen-bit ALU with a flag byte.
// The request channel req_if carries an operation code, two operands and
// the current flag byte; the response channel rsp_if returns the result
// and the updated flag byte, one response for every request, in order.
// Both channels use a valid/ready handshake; a transfer happens on a
// rising clock edge where valid and ready are both high.
// A request transfer is captured in the input register, the ALU logic
// between the input and output registers computes the response, and the
// response is shown on rsp_if once it is loaded into the output register.
// Throughput is one operation per cycle while rsp_if.ready is high, set by the
// single pass through the ALU logic; the input register advances whenever the
// output register is empty or is being drained in the same cycle.
// When the receiver holds rsp_if.ready low, the output register keeps its
// response and the input register fills; req_if.ready then drops until the
// response is taken. The block has no configuration and no stored state
// beyond the two pipeline registers.
// A synchronous reset empties both registers.
module cpu_alu_with_flags (
   input logic        clock,
   input logic        reset,
   cawf_req_if.sink   req_if,
   cawf_rsp_if.source rsp_if
);
   import cawf_pkg::*;

`include "cpu_alu_with_flags_assert.svh"

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_payload_type s1_payload_ff;
   req_payload_type req_payload;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_payload_ff;
   rsp_payload_type alu_rsp;
   logic            out_free;
   logic            s1_free;
   logic            req_transfer;

   // Handshake and occupancy of the two pipeline stages.
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign s1_free      = !s1_valid_ff || out_free;
   assign req_transfer = req_if.valid && s1_free;
   assign req_if.ready = s1_free;

   assign s1_valid_in  = req_transfer || (s1_valid_ff && !out_free);
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   assign req_payload.action    = req_if.action;
   assign req_payload.operand_a = req_if.operand_a;
   assign req_payload.operand_b = req_if.operand_b;
   assign req_payload.flags_in  = req_if.flags_in;

   // Result and flag logic between the input and output registers.
   cawf_alu u_alu (
      .req_payload (s1_payload_ff),
      .rsp_payload (alu_rsp)
   );

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only when their stage advances.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_payload_ff <= req_payload;
      end
      if (out_free && s1_valid_ff) begin
         out_payload_ff <= alu_rsp;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.result    = out_payload_ff.result;
   assign rsp_if.flags_out = out_payload_ff.flags_out;

   // A computed item moves into the output register when that register is free.
   `CAWF_ASSERT_NXT(a_stage_advance, clock, reset, s1_valid_ff && out_free, out_valid_ff, "input stage item was not moved to the output register")

   // A blocked input stage keeps its item.
   `CAWF_ASSERT_NXT(a_stage_hold, clock, reset, s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_payload_ff), "blocked input stage lost or changed its item")

   // Eight-bit operations leave the high byte of the result clear.
   `CAWF_ASSERT_IMP(a_byte_result, clock, reset, s1_valid_ff && (s1_payload_ff.action <= ACT_SRL), alu_rsp.result[15:8] == 8'd0, "eight-bit operation produced a nonzero high byte")

   // Unused operation codes give zero and pass the flags through.
   `CAWF_ASSERT_IMP(a_unused_code, clock, reset, s1_valid_ff && (s1_payload_ff.action > ACT_WDEC), (alu_rsp.result == 16'd0) && (alu_rsp.flags_out == s1_payload_ff.flags_in), "unused operation code changed result or flags")

endmodule

### src/cawf_alu.sv
module cawf_alu (
   input  cawf_pkg::req_payload_type req_payload,
   output cawf_pkg::rsp_payload_type rsp_payload
);
   import cawf_pkg::*;

   // Flag bit positions in the flag byte.
   localparam int FlagS  = 7;
   localparam int FlagZ  = 6;
   localparam int FlagH  = 4;
   localparam int FlagPv = 2;
   localparam int FlagC  = 0;

   // Flags written by each group of operations.
   localparam logic [FlagWidth-1:0] MaskArith  = 8'hD5;
   localparam logic [FlagWidth-1:0] MaskRotate = 8'h13;
   localparam logic [FlagWidth-1:0] MaskShift  = 8'hFF;
   localparam logic [FlagWidth-1:0] MaskWadd   = 8'h13;
   localparam logic [FlagWidth-1:0] MaskWide   = 8'hD7;

   logic [7:0]           a;
   logic [7:0]           b;
   logic [DataWidth-1:0] wa;
   logic [DataWidth-1:0] wb;
   logic                 c;
   logic                 c_adc;
   logic                 c_sbc;
   logic                 c_wadc;
   logic [8:0]           sum8;
   logic [4:0]           hsum8;
   logic [8:0]           dif8;
   logic [4:0]           hdif8;
   logic [7:0]           inc8;
   logic [7:0]           dec8;
   logic [16:0]          sum16;
   logic [12:0]          hsum16;
   logic [16:0]          dif16;
   logic [12:0]          hdif16;
   logic [DataWidth-1:0] res;
   logic [FlagWidth-1:0] fval;
   logic [FlagWidth-1:0] fmask;

   assign a  = req_payload.operand_a[7:0];
   assign b  = req_payload.operand_b[7:0];
   assign wa = req_payload.operand_a;
   assign wb = req_payload.operand_b;
   assign c  = req_payload.flags_in[FlagC];

   // The carry flag feeds the adders only for the with-carry operations; the 16-bit subtract always takes it.
   assign c_adc  = c & (req_payload.action == ACT_ADC);
   assign c_sbc  = c & (req_payload.action == ACT_SBC);
   assign c_wadc = c & (req_payload.action == ACT_WADC);

   // Eight-bit adders; the top bit of each sum and difference is the carry or borrow out.
   assign sum8  = {1'b0, a} + {1'b0, b} + {8'd0, c_adc};
   assign hsum8 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_adc};
   assign dif8  = {1'b0, a} - {1'b0, b} - {8'd0, c_sbc};
   assign hdif8 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_sbc};
   assign inc8  = a + 8'd1;
   assign dec8  = a - 8'd1;

   // Sixteen-bit adders; the half carry comes out of bit 11.
   assign sum16  = {1'b0, wa} + {1'b0, wb} + {16'd0, c_wadc};
   assign hsum16 = {1'b0, wa[11:0]} + {1'b0, wb[11:0]} + {12'd0, c_wadc};
   assign dif16  = {1'b0, wa} - {1'b0, wb} - {16'd0, c};
   assign hdif16 = {1'b0, wa[11:0]} - {1'b0, wb[11:0]} - {12'd0, c};

   // Select the result, the new flag values and the mask of flags written.
   always_comb begin
      res   = '0;
      fval  = '0;
      fmask = '0;
      case (req_payload.action)
         ACT_ADD, ACT_ADC: begin
            res          = {8'd0, sum8[7:0]};
            fval[FlagC]  = sum8[8];
            fval[FlagH]  = hsum8[4];
            fval[FlagPv] = ~(a[7] ^ b[7]) & (a[7] ^ sum8[7]);
            fval[FlagS]  = sum8[7];
            fval[FlagZ]  = (sum8[7:0] == 8'd0);
            fmask        = MaskArith;
         end
         ACT_SUB, ACT_SBC: begin
            res          = {8'd0, dif8[7:0]};
            fval[FlagC]  = dif8[8];
            fval[FlagH]  = hdif8[4];
            fval[FlagPv] = (a[7] ^ b[7]) & (a[7] ^ dif8[7]);
            fval[FlagS]  = dif8[7];
            fval[FlagZ]  = (dif8[7:0] == 8'd0);
            fmask        = MaskArith;
         end
         ACT_AND, ACT_OR, ACT_XOR: begin
            if (req_payload.action == ACT_AND) begin
               res = {8'd0, a & b};
            end else if (req_payload.action == ACT_OR) begin
               res = {8'd0, a | b};
            end else begin
               res = {8'd0, a ^ b};
            end
            fval[FlagS] = res[7];
            fval[FlagZ] = (res[7:0] == 8'd0);
            fmask       = MaskArith;
         end
         ACT_INC: begin
            res          = {8'd0, inc8};
            fval[FlagC]  = c;
            fval[FlagH]  = (inc8[3:0] == 4'd0);
            fval[FlagPv] = (inc8 == 8'h80);
            fval[FlagS]  = inc8[7];
            fval[FlagZ]  = (inc8 == 8'd0);
            fmask        = MaskArith;
         end
         ACT_DEC: begin
            res          = {8'd0, dec8};
            fval[FlagC]  = c;
            fval[FlagH]  = (a[3:0] == 4'd0);
            fval[FlagPv] = (dec8 == 8'h7F);
            fval[FlagS]  = dec8[7];
            fval[FlagZ]  = (dec8 == 8'd0);
            fmask        = MaskArith;
         end
         ACT_RLC: begin
            res         = {8'd0, a[6:0], a[7]};
            fval[FlagC] = a[7];
            fmask       = MaskRotate;
         end
         ACT_RLA: begin
            res         = {8'd0, a[6:0], c};
            fval[FlagC] = a[7];
            fmask       = MaskRotate;
         end
         ACT_RRC: begin
            res         = {8'd0, a[0], a[7:1]};
            fval[FlagC] = a[0];
            fmask       = MaskRotate;
         end
         ACT_RRA: begin
            res         = {8'd0, c, a[7:1]};
            fval[FlagC] = a[0];
            fmask       = MaskRotate;
         end
         ACT_SLA, ACT_SRA, ACT_SRL: begin
            if (req_payload.action == ACT_SLA) begin
               res         = {8'd0, a[6:0], 1'b0};
               fval[FlagC] = a[7];
            end else if (req_payload.action == ACT_SRA) begin
               res         = {8'd0, a[7], a[7:1]};
               fval[FlagC] = a[0];
            end else begin
               res         = {8'd0, 1'b0, a[7:1]};
               fval[FlagC] = a[0];
            end
            // Shifts rewrite the whole byte; parity flag means even parity.
            fval[FlagS]  = res[7];
            fval[FlagZ]  = (res[7:0] == 8'd0);
            fval[FlagPv] = ~^res[7:0];
            fmask        = MaskShift;
         end
         ACT_WADD: begin
            res         = sum16[15:0];
            fval[FlagC] = sum16[16];
            fval[FlagH] = hsum16[12];
            fmask       = MaskWadd;
         end
         ACT_WADC: begin
            res          = sum16[15:0];
            fval[FlagC]  = sum16[16];
            fval[FlagH]  = hsum16[12];
            fval[FlagPv] = ~(wa[15] ^ wb[15]) & (wa[15] ^ sum16[15]);
            fval[FlagS]  = sum16[15];
            fval[FlagZ]  = (sum16[15:0] == 16'd0);
            fmask        = MaskWide;
         end
         ACT_WSBC: begin
            res          = dif16[15:0];
            fval[FlagC]  = dif16[16];
            fval[FlagH]  = hdif16[12];
            fval[FlagPv] = (wa[15] ^ wb[15]) & (wa[15] ^ dif16[15]);
            fval[FlagS]  = dif16[15];
            fval[FlagZ]  = (dif16[15:0] == 16'd0);
            fmask        = MaskWide;
         end
         ACT_WINC: begin
            res = wa + 16'd1;
         end
         ACT_WDEC: begin
            res = wa - 16'd1;
         end
         default: begin
            res   = '0;
            fmask = '0;
         end
      endcase
   end

   // Flags outside the mask pass through unchanged.
   assign rsp_payload.result    = res;
   assign rsp_payload.flags_out = (req_payload.flags_in & ~fmask) | (fval & fmask);

endmodule

### tb/tb_cpu_alu_with_flags.sv
module tb_cpu_alu_with_flags;
   import cawf_pkg::*;

   // Flag byte bit positions.
   localparam logic [7:0] FLAG_S  = 8'h80;
   localparam logic [7:0] FLAG_Z  = 8'h40;
   localparam logic [7:0] FLAG_H  = 8'h10;
   localparam logic [7:0] FLAG_PV = 8'h04;
   localparam logic [7:0] FLAG_N  = 8'h02;
   localparam logic [7:0] FLAG_C  = 8'h01;

   // Operation codes that the block does not define.
   localparam logic [4:0] ACT_UNUSED_LO = 5'd21;
   localparam logic [4:0] ACT_UNUSED_HI = 5'd31;

   localparam int RANDOM_ITEMS = 1000;

   // Expected ALU responses, predicted from each accepted request.
   class alu_scoreboard;
      rsp_payload_type expected_q[$];
      int unsigned     mismatches;
      int unsigned     checked;
      logic [31:0]     actions_seen;

      function new();
         mismatches   = 0;
         checked      = 0;
         actions_seen = '0;
      endfunction

      function logic [7:0] merge_bits(logic [7:0] f, logic [7:0] mask, logic [7:0] v);
         return (f & ~mask) | (v & mask);
      endfunction

      // Flag update shared by the eight-bit arithmetic and logic operations.
      function logic [7:0] arith_flags(logic [7:0] f, logic [7:0] r, logic c, logic h,
                                       logic o);
         return merge_bits(f, FLAG_S | FLAG_Z | FLAG_H | FLAG_PV | FLAG_C,
                           {r[7], r == 8'h00, 1'b0, h, 1'b0, o, 1'b0, c});
      endfunction

      // Shifts rewrite the whole flag byte; PV is even parity.
      function logic [7:0] shift_flags(logic [7:0] r, logic c);
         return {r[7], r == 8'h00, 3'b000, ~^r, 1'b0, c};
      endfunction

      function rsp_payload_type alu_predict(req_payload_type q);
         logic [7:0]      a, b, f, r8, nf;
         logic [15:0]     wa, wb, r16;
         logic            cin, wide, ov, hc, cy;
         logic [8:0]      s9;
         logic [4:0]      s5;
         logic [16:0]     s17;
         logic [12:0]     s13;
         rsp_payload_type p;
         a    = q.operand_a[7:0];
         b    = q.operand_b[7:0];
         wa   = q.operand_a;
         wb   = q.operand_b;
         f    = q.flags_in;
         cin  = f[0];
         nf   = f;
         r8   = 8'h00;
         r16  = 16'h0000;
         wide = 1'b0;
         case (q.action)
            ACT_ADD, ACT_ADC: begin
               if (q.action == ACT_ADD) cin = 1'b0;
               s9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
               s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
               r8 = s9[7:0];
               ov = (a[7] == b[7]) && (a[7] != r8[7]);
               nf = arith_flags(f, r8, s9[8], s5[4], ov);
            end
            ACT_SUB, ACT_SBC: begin
               // Bit 8 and bit 4 of the differences are the borrows.
               if (q.action == ACT_SUB) cin = 1'b0;
               s9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
               s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
               r8 = s9[7:0];
               ov = (a[7] != b[7]) && (a[7] != r8[7]);
               nf = arith_flags(f, r8, s9[8], s5[4], ov);
            end
            ACT_AND: begin
               r8 = a & b;
               nf = arith_flags(f, r8, 1'b0, 1'b0, 1'b0);
            end
            ACT_OR: begin
               r8 = a | b;
               nf = arith_flags(f, r8, 1'b0, 1'b0, 1'b0);
            end
            ACT_XOR: begin
               r8 = a ^ b;
               nf = arith_flags(f, r8, 1'b0, 1'b0, 1'b0);
            end
            ACT_INC: begin
               r8 = a + 8'd1;
               nf = arith_flags(f, r8, cin, r8[3:0] == 4'h0, r8 == 8'h80);
            end
            ACT_DEC: begin
               r8 = a - 8'd1;
               nf = arith_flags(f, r8, cin, a[3:0] == 4'h0, r8 == 8'h7F);
            end
            ACT_RLC: begin
               r8 = {a[6:0], a[7]};
               nf = merge_bits(f, FLAG_C | FLAG_N | FLAG_H, {7'd0, a[7]});
            end
            ACT_RLA: begin
               r8 = {a[6:0], cin};
               nf = merge_bits(f, FLAG_C | FLAG_N | FLAG_H, {7'd0, a[7]});
            end
            ACT_RRC: begin
               r8 = {a[0], a[7:1]};
               nf = merge_bits(f, FLAG_C | FLAG_N | FLAG_H, {7'd0, a[0]});
            end
            ACT_RRA: begin
               r8 = {cin, a[7:1]};
               nf = merge_bits(f, FLAG_C | FLAG_N | FLAG_H, {7'd0, a[0]});
            end
            ACT_SLA: begin
               r8 = {a[6:0], 1'b0};
               nf = shift_flags(r8, a[7]);
            end
            ACT_SRA: begin
               r8 = {a[7], a[7:1]};
               nf = shift_flags(r8, a[0]);
            end
            ACT_SRL: begin
               r8 = {1'b0, a[7:1]};
               nf = shift_flags(r8, a[0]);
            end
            ACT_WADD: begin
               wide = 1'b1;
               s17  = {1'b0, wa} + {1'b0, wb};
               s13  = {1'b0, wa[11:0]} + {1'b0, wb[11:0]};
               r16  = s17[15:0];
               nf   = merge_bits(f, FLAG_H | FLAG_N | FLAG_C,
                                 {3'b000, s13[12], 3'b000, s17[16]});
            end
            ACT_WADC, ACT_WSBC: begin
               wide = 1'b1;
               if (q.action == ACT_WADC) begin
                  s17 = {1'b0, wa} + {1'b0, wb} + {16'd0, cin};
                  s13 = {1'b0, wa[11:0]} + {1'b0, wb[11:0]} + {12'd0, cin};
                  ov  = (wa[15] == wb[15]) && (wa[15] != s17[15]);
               end else begin
                  s17 = {1'b0, wa} - {1'b0, wb} - {16'd0, cin};
                  s13 = {1'b0, wa[11:0]} - {1'b0, wb[11:0]} - {12'd0, cin};
                  ov  = (wa[15] != wb[15]) && (wa[15] != s17[15]);
               end
               r16 = s17[15:0];
               hc  = s13[12];
               cy  = s17[16];
               nf  = merge_bits(f, FLAG_S | FLAG_Z | FLAG_H | FLAG_PV | FLAG_N | FLAG_C,
                                {r16[15], r16 == 16'h0000, 1'b0, hc, 1'b0, ov, 1'b0, cy});
            end
            ACT_WINC: begin
               wide = 1'b1;
               r16  = wa + 16'd1;
            end
            ACT_WDEC: begin
               wide = 1'b1;
               r16  = wa - 16'd1;
            end
            default: begin
               r8 = 8'h00;
               nf = f;
            end
         endcase
         if (!wide) r16 = {8'h00, r8};
         p.result    = r16;
         p.flags_out = nf;
         return p;
      endfunction

      function void note_request(req_payload_type q);
         expected_q.push_back(alu_predict(q));
         actions_seen[q.action] = 1'b1;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("response %h/%h with no request outstanding",
                                      got.result, got.flags_out));
         end else begin
            want = expected_q.pop_front();
            if (got.result !== want.result)
               report_mismatch($sformatf("response %0d result %h, expected %h",
                                         checked, got.result, want.result));
            if (got.flags_out !== want.flags_out)
               report_mismatch($sformatf("response %0d flags %b, expected %b",
                                         checked, got.flags_out, want.flags_out));
         end
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   bit   steady;

   cawf_req_if req_ch ();
   cawf_rsp_if rsp_ch ();

   alu_scoreboard sb = new();

   cpu_alu_with_flags dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Receiver side: hold ready low at random, 16 percent of the time, outside steady stretches.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= steady || ($urandom_range(99) >= 16);
      end
   end

   // Record every request transfer and check every response transfer.
   always @(posedge clock) begin
      req_payload_type seen_req;
      rsp_payload_type seen_rsp;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_req.action    = req_ch.action;
            seen_req.operand_a = req_ch.operand_a;
            seen_req.operand_b = req_ch.operand_b;
            seen_req.flags_in  = req_ch.flags_in;
            sb.note_request(seen_req);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_rsp.result    = rsp_ch.result;
            seen_rsp.flags_out = rsp_ch.flags_out;
            sb.check_response(seen_rsp);
         end
      end
   end

   // Drive one request and return at the edge where it transfers.
   task send_op(input logic [4:0] act, input logic [15:0] opa, input logic [15:0] opb,
                input logic [7:0] fin);
      while (!steady && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.operand_a <= opa;
      req_ch.operand_b <= opb;
      req_ch.flags_in  <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Operand values lean toward the carry, overflow and nibble boundaries.
   function logic [15:0] pick_operand();
      if ($urandom_range(3) != 0) return 16'($urandom_range(65535));
      case ($urandom_range(8))
         0: return 16'h0000;
         1: return 16'h000F;
         2: return 16'h007F;
         3: return 16'h0080;
         4: return 16'h00FF;
         5: return 16'h0FFF;
         6: return 16'h7FFF;
         7: return 16'h8000;
         default: return 16'hFFFF;
      endcase
   endfunction

   initial begin
      logic [4:0] act;
      reset            <= 1'b1;
      steady           = 1'b0;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= ACT_ADD;
      req_ch.operand_a <= '0;
      req_ch.operand_b <= '0;
      req_ch.flags_in  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Eight-bit arithmetic and logic: signed overflow, carry out, half carry and half borrow.
      send_op(ACT_ADD, 16'h007F, 16'h0001, 8'h00);
      send_op(ACT_ADD, 16'hABFF, 16'hCD01, 8'hFF);
      send_op(ACT_ADC, 16'h000F, 16'h0000, 8'h01);
      send_op(ACT_SUB, 16'h0010, 16'h0001, 8'h00);
      send_op(ACT_SUB, 16'h0080, 16'h0001, 8'hFF);
      send_op(ACT_SBC, 16'h0010, 16'h000F, 8'h01);
      send_op(ACT_SBC, 16'h0000, 16'h0000, 8'h01);
      send_op(ACT_AND, 16'h00FF, 16'h0000, 8'hFF);
      send_op(ACT_OR,  16'h0000, 16'h0000, 8'h00);
      send_op(ACT_XOR, 16'h00FF, 16'h007F, 8'hFF);
      // Increment half carry comes from a zero low nibble of the result.
      send_op(ACT_INC, 16'h007F, 16'h0000, 8'h00);
      send_op(ACT_INC, 16'h00FF, 16'hFFFF, 8'h01);
      send_op(ACT_DEC, 16'h0080, 16'h0000, 8'h00);
      send_op(ACT_DEC, 16'h0000, 16'h0000, 8'hFF);
      // Rotates touch only C, N and H; shifts clear the unused bits 5 and 3.
      send_op(ACT_RLC, 16'h0080, 16'h0000, 8'hFF);
      send_op(ACT_RLA, 16'h0080, 16'h0000, 8'h01);
      send_op(ACT_RRC, 16'h0001, 16'h0000, 8'h00);
      send_op(ACT_RRA, 16'h0001, 16'h0000, 8'h01);
      send_op(ACT_SLA, 16'h00C0, 16'h0000, 8'hFF);
      send_op(ACT_SRA, 16'h0081, 16'h0000, 8'h00);
      send_op(ACT_SRL, 16'h0001, 16'h0000, 8'hFF);
      // Wide operations, wrap-around and the undefined codes.
      send_op(ACT_WADD, 16'h0FFF, 16'h0001, 8'hFF);
      send_op(ACT_WADD, 16'hFFFF, 16'h0001, 8'h00);
      send_op(ACT_WADC, 16'h7FFF, 16'h0000, 8'h01);
      send_op(ACT_WSBC, 16'h1234, 16'h1233, 8'h01);
      send_op(ACT_WSBC, 16'h8000, 16'h0001, 8'h00);
      send_op(ACT_WINC, 16'hFFFF, 16'h0000, 8'h00);
      send_op(ACT_WDEC, 16'h0000, 16'h0000, 8'hFF);
      send_op(ACT_UNUSED_LO, 16'hFFFF, 16'hFFFF, 8'hA5);
      send_op(ACT_UNUSED_HI, 16'h1234, 16'h5678, 8'h5A);

      // Random operations, with a stretch where neither side idles.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 400 && i < 600);
         if ($urandom_range(99) < 5)
            act = 5'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
         else
            act = 5'($urandom_range(ACT_WDEC, ACT_ADD));
         send_op(act, pick_operand(), pick_operand(), 8'($urandom_range(255)));
      end
      req_ch.valid <= 1'b0;
      steady = 1'b0;

      // Drain the pipeline, then wait for any stray responses.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      if (sb.expected_q.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.expected_q.size()));
      $display("Checked %0d responses covering %0d of 32 operation codes,",
               sb.checked, $countones(sb.actions_seen));
      $display("with random stalls on both channels and one stall-free stretch.");
      if (sb.mismatches == 0) begin
         $display("** cpu_alu_with_flags: PASSED **");
      end else begin
         $display("** cpu_alu_with_flags: FAILED **");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("Timeout with %0d responses outstanding.", sb.expected_q.size());
      $display("** cpu_alu_with_flags: FAILED **");
      $finish;
   end

endmodule
